>>> design/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mctt_pkg.sv
// Package for the multi-category top-ten tracker: opcodes, states, item and entry types.
// Used by mctt_store, mctt_seq and the top level; depends on nothing.
`timescale 1ns / 1ps

package mctt_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] CAT_POSTS    = 3'd0;
    localparam logic [2:0] CAT_LOGONS   = 3'd1;
    localparam logic [2:0] CAT_UPLOAD   = 3'd2;
    localparam logic [2:0] CAT_DOWNLOAD = 3'd3;
    localparam logic [2:0] CAT_MINUTES  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] user_number;
        logic        deleted_flag;
        logic [31:0] post_count;
        logic [31:0] logon_count;
        logic [31:0] upload_kb;
        logic [31:0] download_kb;
        logic [31:0] minutes_online;
        logic [2:0]  category;
        logic [3:0]  rank;
    } item_t;

    typedef struct packed {
        logic [15:0] user;
        logic [31:0] value;
    } entry_t;

    // Control from the sequencer to the list store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } mem_ctl_t;

    // Status from the sequencer to the top level.
    typedef struct packed {
        logic busy;
        logic res_valid;
    } seq_stat_t;

    function automatic logic [31:0] count_for(input item_t it, input logic [2:0] cat);
        logic [31:0] v;
        case (cat)
            CAT_POSTS:    v = it.post_count;
            CAT_LOGONS:   v = it.logon_count;
            CAT_UPLOAD:   v = it.upload_kb;
            CAT_DOWNLOAD: v = it.download_kb;
            CAT_MINUTES:  v = it.minutes_online;
            default:      v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/mctt_store.sv
// Ranked list store: one memory holding every list, one write and one registered read port.
// Per-entry valid bits make reset and clear immediate. Depends on mctt_pkg.
`timescale 1ns / 1ps

module mctt_store
    import mctt_pkg::*;
#(
    parameter int SLOT_COUNT = 50,
    parameter int SLOT_W     = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mem_ctl_t          ctl,
    input  logic [SLOT_W-1:0] waddr,
    input  entry_t            wentry,
    input  logic [SLOT_W-1:0] raddr,
    output entry_t            rentry
);

    entry_t                  mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]   valid_reg;
    entry_t                  rdata_reg;
    logic                    rvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr) begin
            valid_reg <= '0;
        end else if (ctl.wr_en) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[waddr] <= wentry;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rdata_reg  <= mem[raddr];
            rvalid_reg <= valid_reg[raddr];
        end
    end

    // An entry never written since reset or clear reads as an empty slot.
    assign rentry = rvalid_reg ? rdata_reg : '0;

endmodule

>>> design/mctt_seq.sv
// Sequencer and shared compare unit: walks every list slot by slot for an insert,
// carrying displaced entries down, and serves reads and clears. Depends on mctt_pkg.
`timescale 1ns / 1ps

module mctt_seq
    import mctt_pkg::*;
#(
    parameter int LIST_DEPTH     = 10,
    parameter int CATEGORY_COUNT = 5,
    parameter int SLOT_W         = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  item_t             s_item,
    input  logic              res_ready,
    output seq_stat_t         stat,
    output entry_t            res_entry,
    output logic              res_filled,
    output mem_ctl_t          ctl,
    output logic [SLOT_W-1:0] waddr,
    output entry_t            wentry,
    output logic [SLOT_W-1:0] raddr,
    input  entry_t            rentry
);

    localparam int CAT_W = (CATEGORY_COUNT > 1) ? $clog2(CATEGORY_COUNT) : 1;
    localparam int POS_W = $clog2(LIST_DEPTH);
    localparam int LIN_W = SLOT_W + 4;

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [CAT_W-1:0]  cat_reg, cat_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SLOT_W-1:0] addr_reg, addr_next;
    entry_t            carry_reg, carry_next;
    logic              carry_act_reg, carry_act_next;
    logic              range_ok_reg, range_ok_next;

    logic [31:0]       scan_val;
    logic              val_ok;
    logic              hit;
    logic              last_pos;
    logic              last_cat;
    logic [LIN_W-1:0]  rd_lin;
    logic              rd_in_range;

    assign scan_val = count_for(item_reg, 3'(cat_reg));
    // Transfer categories only take values above zero.
    assign val_ok   = !(((3'(cat_reg) == CAT_UPLOAD) || (3'(cat_reg) == CAT_DOWNLOAD))
                        && (scan_val == 32'd0));
    assign hit      = val_ok && !carry_act_reg && (scan_val >= rentry.value);
    assign last_pos = (pos_reg == POS_W'(LIST_DEPTH - 1));
    assign last_cat = (cat_reg == CAT_W'(CATEGORY_COUNT - 1));

    assign rd_lin = LIN_W'(s_item.category) * LIN_W'(LIST_DEPTH) + LIN_W'(s_item.rank);
    assign rd_in_range = (32'(s_item.category) < CATEGORY_COUNT)
                         && (32'(s_item.rank) < LIST_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            carry_act_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            carry_act_reg <= carry_act_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        cat_reg      <= cat_next;
        pos_reg      <= pos_next;
        addr_reg     <= addr_next;
        carry_reg    <= carry_next;
        range_ok_reg <= range_ok_next;
    end

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        cat_next       = cat_reg;
        pos_next       = pos_reg;
        addr_next      = addr_reg;
        carry_next     = carry_reg;
        carry_act_next = carry_act_reg;
        range_ok_next  = range_ok_reg;
        ctl            = '0;
        raddr          = '0;
        waddr          = addr_reg;
        wentry         = carry_reg;
        s_ready        = 1'b0;
        stat.res_valid = 1'b0;
        stat.busy      = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                stat.busy = 1'b0;
                if (s_valid) begin
                    item_next = s_item;
                    unique case (s_item.opcode)
                        OP_INSERT: begin
                            if (!s_item.deleted_flag) begin
                                ctl.rd_en      = 1'b1;
                                cat_next       = '0;
                                pos_next       = '0;
                                addr_next      = '0;
                                carry_act_next = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        OP_READ: begin
                            ctl.rd_en     = 1'b1;
                            raddr         = rd_in_range ? rd_lin[SLOT_W-1:0] : '0;
                            range_ok_next = rd_in_range;
                            state_next    = ST_READ;
                        end
                        OP_CLEAR: begin
                            ctl.clr = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // The slot at addr_reg is in rentry; the next slot is read meanwhile.
                ctl.rd_en = 1'b1;
                raddr     = (last_pos && last_cat) ? '0 : addr_reg + 1'b1;
                if (carry_act_reg || hit) begin
                    ctl.wr_en      = 1'b1;
                    wentry         = carry_act_reg ? carry_reg
                                                   : entry_t'{user: item_reg.user_number,
                                                              value: scan_val};
                    carry_next     = rentry;
                    carry_act_next = 1'b1;
                end
                addr_next = addr_reg + 1'b1;
                pos_next  = pos_reg + 1'b1;
                if (last_pos) begin
                    // The entry carried past the last slot drops off the list.
                    carry_act_next = 1'b0;
                    pos_next       = '0;
                    cat_next       = cat_reg + 1'b1;
                    if (last_cat) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                stat.res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_entry  = range_ok_reg ? rentry : '0;
    assign res_filled = (res_entry.user != 16'd0);

endmodule

>>> design/multi_category_top_ten_tracker_core.sv
// Top level of the multi-category top-ten tracker: stream ports, output register, assertions.
// Instantiates mctt_seq and mctt_store; depends on mctt_pkg and assert_macros.svh.
//
//  Channel   Direction  tdata fields (low bit up)                         tuser
//  s_        in         user_number, deleted_flag, post_count,            opcode
//                       logon_count, upload_kb, download_kb,
//                       minutes_online, category, rank (184 bits)
//  m_        out        entry_user, entry_value, entry_filled, zero pad   none
//
// An insert walks all LIST_DEPTH * CATEGORY_COUNT slots through one compare unit and the
// store's read and write ports; a deleted insert, a clear and an unused opcode are handled in
// the idle state; a read goes through the read state and waits there for the output register.
// s_tready is high only while the sequencer is idle. Reset and clear empty all lists at once
// through per-slot valid bits. A read result waits in the sequencer while m_ holds a result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_category_top_ten_tracker_core
    import mctt_pkg::*;
#(
    parameter int LIST_DEPTH     = 10,
    parameter int CATEGORY_COUNT = 5
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // user_number, deleted_flag, post_count, logon_count, upload_kb, download_kb,
    // minutes_online, category, rank
    input  logic [183:0] s_tdata,
    // opcode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_user, entry_value, entry_filled, 7 zero bits
    output logic [55:0]  m_tdata
);

    localparam int SLOT_COUNT = LIST_DEPTH * CATEGORY_COUNT;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    item_t             s_item;
    seq_stat_t         stat;
    entry_t            res_entry;
    logic              res_filled;
    logic              res_ready;
    mem_ctl_t          ctl;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] raddr;
    entry_t            wentry;
    entry_t            rentry;

    logic              m_valid_reg, m_valid_next;
    entry_t            m_entry_reg;
    logic              m_filled_reg;

    assign s_item.opcode         = s_tuser;
    assign s_item.user_number    = s_tdata[15:0];
    assign s_item.deleted_flag   = s_tdata[16];
    assign s_item.post_count     = s_tdata[48:17];
    assign s_item.logon_count    = s_tdata[80:49];
    assign s_item.upload_kb      = s_tdata[112:81];
    assign s_item.download_kb    = s_tdata[144:113];
    assign s_item.minutes_online = s_tdata[176:145];
    assign s_item.category       = s_tdata[179:177];
    assign s_item.rank           = s_tdata[183:180];

    mctt_seq #(
        .LIST_DEPTH     (LIST_DEPTH),
        .CATEGORY_COUNT (CATEGORY_COUNT),
        .SLOT_W         (SLOT_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .res_ready  (res_ready),
        .stat       (stat),
        .res_entry  (res_entry),
        .res_filled (res_filled),
        .ctl        (ctl),
        .waddr      (waddr),
        .wentry     (wentry),
        .raddr      (raddr),
        .rentry     (rentry)
    );

    mctt_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .waddr   (waddr),
        .wentry  (wentry),
        .raddr   (raddr),
        .rentry  (rentry)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (stat.res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.res_valid && res_ready) begin
            m_entry_reg  <= res_entry;
            m_filled_reg <= res_filled;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_filled_reg, m_entry_reg.value, m_entry_reg.user};

    `ASSERT_SAME(a_busy_not_ready, stat.busy, !s_tready, "input taken while sequencer busy")
    `ASSERT_NEXT(a_read_gives_result, s_tvalid && s_tready && (s_tuser == OP_READ),
                 stat.res_valid, "accepted read did not reach the result stage")
    `ASSERT_NEXT(a_result_held, stat.res_valid && !res_ready, stat.res_valid,
                 "stalled read result was dropped")
    `ASSERT_SAME(a_no_write_idle, !stat.busy, !ctl.wr_en, "list written outside an insert walk")

endmodule
